FILE: src/fplsr_pkg.sv
// Shared types and constants for the fixed-point lane ALU with stochastic rounding.
`default_nettype none
package fplsr_pkg;

  localparam int NUM_LANES  = 32;
  localparam int LANE_IDX_W = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
  localparam int LANE_EXT_W = 7;

  localparam int ROT_A = 13;
  localparam int ROT_B = 5;
  localparam int ROT_C = 10;
  localparam int ROT_D = 9;

  localparam int WIDE_W = 34;

  typedef enum logic [4:0] {
    FN_ADD     = 5'd0,
    FN_SUB     = 5'd1,
    FN_AND     = 5'd2,
    FN_SLL     = 5'd3,
    FN_SRA     = 5'd4,
    FN_MUL     = 5'd5,
    FN_MUL_RN  = 5'd6,
    FN_MUL_RS  = 5'd7,
    FN_SLLI    = 5'd8,
    FN_SRAI    = 5'd9,
    FN_SRAI_RN = 5'd10,
    FN_SRAI_RS = 5'd11,
    FN_RNG     = 5'd12,
    FN_ANDADD  = 5'd13,
    FN_EQ      = 5'd14,
    FN_NE      = 5'd15,
    FN_LT      = 5'd16,
    FN_GE      = 5'd17,
    FN_SEED0   = 5'd18,
    FN_SEED1   = 5'd19
  } func_t;

  typedef struct packed {
    logic [4:0]         func;
    logic [4:0]         lane;
    logic signed [15:0] opnd_a;
    logic signed [15:0] opnd_b;
    logic [3:0]         frac_shift;
    logic               sat_enable;
  } item_t;

endpackage
`default_nettype wire

FILE: src/fplsr_rng.sv
// Per-lane xoroshiro32++ generator state with seed loads and one step per draw.
`default_nettype none
module fplsr_rng
  import fplsr_pkg::*;
(
  input  logic        clk,
  input  logic        fire,
  input  item_t       item,
  output logic [15:0] rnd
);

  function automatic logic [15:0] rotl16(input logic [15:0] x, input int unsigned k);
    return (x << k) | (x >> (16 - k));
  endfunction

  logic [15:0] word0 [NUM_LANES];
  logic [15:0] word1 [NUM_LANES];

  logic [LANE_EXT_W-1:0] lane_ext;
  logic [LANE_IDX_W-1:0] idx;
  logic                  lane_ok;
  logic                  draws;
  logic [15:0]           s0;
  logic [15:0]           s1;
  logic [15:0]           mix;
  logic [15:0]           s0_next;
  logic [15:0]           s1_next;

  assign lane_ext = {2'b00, item.lane};
  assign lane_ok  = lane_ext < LANE_EXT_W'(NUM_LANES);
  assign idx      = lane_ext[LANE_IDX_W-1:0];

  assign draws = (item.func == FN_MUL_RS) || (item.func == FN_SRAI_RS) ||
                 (item.func == FN_RNG);

  assign s0 = lane_ok ? word0[idx] : 16'h0000;
  assign s1 = lane_ok ? word1[idx] : 16'h0000;

  assign rnd     = rotl16(16'(s0 + s1), ROT_D) + s0;
  assign mix     = s1 ^ s0;
  assign s0_next = rotl16(s0, ROT_A) ^ mix ^ (mix << ROT_B);
  assign s1_next = rotl16(mix, ROT_C);

  always_ff @(posedge clk) begin
    if (fire && lane_ok) begin
      if (draws) begin
        word0[idx] <= s0_next;
        word1[idx] <= s1_next;
      end
      if (item.func == FN_SEED0) begin
        word0[idx] <= item.opnd_a;
      end
      if (item.func == FN_SEED1) begin
        word1[idx] <= item.opnd_a;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/fplsr_alu.sv
// Lane datapath: add and subtract, logic, shifts, fixed-point multiply with rounding, random draws, compares.
`default_nettype none
module fplsr_alu
  import fplsr_pkg::*;
(
  input  item_t       item,
  input  logic [15:0] rnd,
  output logic [15:0] result
);

  function automatic logic [15:0] fit16(input logic signed [WIDE_W-1:0] v,
                                        input logic sat);
    logic [15:0] r;
    r = v[15:0];
    if (sat && (v > WIDE_W'(32767))) begin
      r = 16'h7FFF;
    end else if (sat && (v < -WIDE_W'(32768))) begin
      r = 16'h8000;
    end
    return r;
  endfunction

  logic signed [31:0]       prod;
  logic signed [WIDE_W-1:0] a_w;
  logic signed [WIDE_W-1:0] b_w;
  logic signed [WIDE_W-1:0] prod_w;
  logic signed [WIDE_W-1:0] pre;
  logic signed [WIDE_W-1:0] round_add;
  logic signed [WIDE_W-1:0] sum;
  logic signed [WIDE_W-1:0] shr;
  logic signed [WIDE_W-1:0] shl;
  logic [15:0]              mask16;
  logic [15:0]              half16;
  logic [3:0]               amt;
  logic                     is_mul;

  assign prod   = item.opnd_a * item.opnd_b;
  assign a_w    = {{(WIDE_W-16){item.opnd_a[15]}}, item.opnd_a};
  assign b_w    = {{(WIDE_W-16){item.opnd_b[15]}}, item.opnd_b};
  assign prod_w = {{(WIDE_W-32){prod[31]}}, prod};

  assign mask16 = (16'h0001 << item.frac_shift) - 16'h0001;
  assign half16 = (item.frac_shift == 4'd0) ? 16'h0000
                                            : (16'h0001 << (item.frac_shift - 4'd1));

  assign is_mul = (item.func == FN_MUL) || (item.func == FN_MUL_RN) ||
                  (item.func == FN_MUL_RS);
  assign amt    = ((item.func == FN_SLL) || (item.func == FN_SRA)) ? item.opnd_b[3:0]
                                                                   : item.frac_shift;
  assign pre    = is_mul ? prod_w : a_w;

  always_comb begin
    case (item.func)
      FN_MUL_RN, FN_SRAI_RN: round_add = {{(WIDE_W-16){1'b0}}, half16};
      FN_MUL_RS, FN_SRAI_RS: round_add = {{(WIDE_W-16){1'b0}}, rnd & mask16};
      default:               round_add = '0;
    endcase
  end

  assign sum = pre + round_add;
  assign shr = sum >>> amt;
  assign shl = a_w <<< amt;

  always_comb begin
    case (item.func)
      FN_ADD:    result = fit16(a_w + b_w, item.sat_enable);
      FN_SUB:    result = fit16(a_w - b_w, item.sat_enable);
      FN_AND:    result = item.opnd_a & item.opnd_b;
      FN_SLL:    result = fit16(shl, item.sat_enable);
      FN_SRA, FN_MUL, FN_MUL_RN, FN_MUL_RS:
                 result = fit16(shr, item.sat_enable);
      FN_SLLI:   result = shl[15:0];
      FN_SRAI, FN_SRAI_RN, FN_SRAI_RS:
                 result = shr[15:0];
      FN_RNG:    result = {1'b0, rnd[15:1]};
      FN_ANDADD: result = (item.opnd_a & mask16) + item.opnd_b;
      FN_EQ:     result = {15'd0, item.opnd_a == item.opnd_b};
      FN_NE:     result = {15'd0, item.opnd_a != item.opnd_b};
      FN_LT:     result = {15'd0, item.opnd_a < item.opnd_b};
      FN_GE:     result = {15'd0, item.opnd_a >= item.opnd_b};
      default:   result = 16'h0000;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/fixed_point_lane_alu_stochastic_round.sv
// Top level: input register, lane datapath and generator state, result register.
// The input register stages each transaction; it moves into the result register when that
// register is empty or its output is being accepted.
// Throughput: 1 transaction per cycle while the output side accepts results; the input
// register feeds the datapath and generator step, the result register decouples the
// output side. Reset clears the valid flags of both registers; generator state is not
// cleared and must be seeded before a lane draws.
`default_nettype none
module fixed_point_lane_alu_stochastic_round
  import fplsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // func[4:0], lane[9:5], opnd_a[25:10], opnd_b[41:26],
                                     // frac_shift[45:42], sat_enable[46], zero[47]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // result[15:0]
);

  logic        s1_valid;
  item_t       s1_item;
  item_t       s1_item_next;
  logic        advance;
  logic        m_valid;
  logic [15:0] m_data;
  logic [15:0] alu_result;
  logic [15:0] rnd;

  assign s1_item_next.func       = s_axis_tdata[4:0];
  assign s1_item_next.lane       = s_axis_tdata[9:5];
  assign s1_item_next.opnd_a     = s_axis_tdata[25:10];
  assign s1_item_next.opnd_b     = s_axis_tdata[41:26];
  assign s1_item_next.frac_shift = s_axis_tdata[45:42];
  assign s1_item_next.sat_enable = s_axis_tdata[46];

  assign advance       = !m_valid || m_axis_tready;
  assign s_axis_tready = !s1_valid || advance;
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;

  fplsr_rng u_rng (
    .clk  (clk),
    .fire (s1_valid && advance),
    .item (s1_item),
    .rnd  (rnd)
  );

  fplsr_alu u_alu (
    .item   (s1_item),
    .rnd    (rnd),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_valid  <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (advance) begin
        m_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_item <= s1_item_next;
    end
    if (s1_valid && advance) begin
      m_data <= alu_result;
    end
  end

`ifndef SYNTHESIS
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_valid |-> s_axis_tready)
    else $error("input stalled while result register empty");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> m_valid)
    else $error("transaction lost between input and result register");

  a_rise_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(m_valid) |-> $past(s1_valid))
    else $error("result appeared without a staged transaction");

  a_flag_result: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && ((s1_item.func == FN_EQ) || (s1_item.func == FN_NE) ||
      (s1_item.func == FN_LT) || (s1_item.func == FN_GE) ||
      (s1_item.func == FN_SEED0) || (s1_item.func == FN_SEED1)))
    |=> (m_data[15:1] == 15'd0))
    else $error("compare or seed result out of range");
`endif

endmodule
`default_nettype wire

FILE: sim/lane_alu_monitor.sv
// Monitor for the lane ALU: predicts each lane result and compares it on the output stream.
module lane_alu_monitor
  import fplsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // func[4:0], lane[9:5], opnd_a[25:10], opnd_b[41:26],
                                      // frac_shift[45:42], sat_enable[46], zero[47]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // result[15:0]
  output int          mismatches,
  output int          outstanding
);

  logic [15:0] gen_word0 [NUM_LANES];
  logic [15:0] gen_word1 [NUM_LANES];
  logic [15:0] pending_lane_results [$];

  function automatic logic [15:0] rotl16(logic [15:0] x, int k);
    return (x << k) | (x >> (16 - k));
  endfunction

  function automatic logic [15:0] xoro_next(logic [4:0] ln);
    logic [15:0] s0, s1, draw_out;
    s0 = '0;
    s1 = '0;
    if (ln < NUM_LANES) begin
      s0 = gen_word0[ln];
      s1 = gen_word1[ln];
    end
    draw_out = rotl16(s0 + s1, ROT_D) + s0;
    s1 = s1 ^ s0;
    s0 = rotl16(s0, ROT_A) ^ s1 ^ (s1 << ROT_B);
    s1 = rotl16(s1, ROT_C);
    if (ln < NUM_LANES) begin
      gen_word0[ln] = s0;
      gen_word1[ln] = s1;
    end
    return draw_out;
  endfunction

  function automatic logic [15:0] fit_lane(longint v, bit sat);
    if (sat && v > 32767) v = 32767;
    if (sat && v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [15:0] compute_lane_result(logic [47:0] d);
    logic [4:0]  fn;
    logic [4:0]  ln;
    logic [15:0] draw_val;
    logic [15:0] res;
    longint      a, b, half, mask;
    int          fs, bs;
    bit          sat;
    fn   = d[4:0];
    ln   = d[9:5];
    a    = $signed(d[25:10]);
    b    = $signed(d[41:26]);
    fs   = d[45:42];
    sat  = d[46];
    bs   = d[29:26];
    half = (fs != 0) ? (longint'(1) << (fs - 1)) : 0;
    mask = (longint'(1) << fs) - 1;
    res  = '0;
    case (fn)
      FN_ADD:     res = fit_lane(a + b, sat);
      FN_SUB:     res = fit_lane(a - b, sat);
      FN_AND:     res = fit_lane(a & b, sat);
      FN_SLL:     res = fit_lane(a * (longint'(1) << bs), sat);
      FN_SRA:     res = fit_lane(a >>> bs, sat);
      FN_MUL:     res = fit_lane((a * b) >>> fs, sat);
      FN_MUL_RN:  res = fit_lane((a * b + half) >>> fs, sat);
      FN_MUL_RS: begin
        draw_val = xoro_next(ln);
        res = fit_lane((a * b + (longint'(draw_val) & mask)) >>> fs, sat);
      end
      FN_SLLI:    res = fit_lane(a * (longint'(1) << fs), 1'b0);
      FN_SRAI:    res = fit_lane(a >>> fs, 1'b0);
      FN_SRAI_RN: res = fit_lane((a + half) >>> fs, 1'b0);
      FN_SRAI_RS: begin
        draw_val = xoro_next(ln);
        res = fit_lane((a + (longint'(draw_val) & mask)) >>> fs, 1'b0);
      end
      FN_RNG: begin
        draw_val = xoro_next(ln);
        res = draw_val >> 1;
      end
      FN_ANDADD:  res = fit_lane((a & mask) + b, 1'b0);
      FN_EQ:      res = (a == b) ? 16'd1 : 16'd0;
      FN_NE:      res = (a != b) ? 16'd1 : 16'd0;
      FN_LT:      res = (a < b) ? 16'd1 : 16'd0;
      FN_GE:      res = (a >= b) ? 16'd1 : 16'd0;
      FN_SEED0: begin
        if (ln < NUM_LANES) gen_word0[ln] = d[25:10];
      end
      FN_SEED1: begin
        if (ln < NUM_LANES) gen_word1[ln] = d[25:10];
      end
      default:    res = '0;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_lane_results.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none, actual %h", $time, m_axis_tdata);
        end else begin
          want = pending_lane_results.pop_front();
          if (m_axis_tdata !== want) begin
            mismatches++;
            $display("%0t: result expected %h, actual %h", $time, want, m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_lane_results.push_back(compute_lane_result(s_axis_tdata));
      end
    end
    outstanding <= pending_lane_results.size();
  end

endmodule

FILE: sim/testbench.sv
// Testbench top: clock, reset, directed and random lane ALU traffic, and the verdict.
module testbench;
  import fplsr_pkg::*;

  localparam int RANDOM_ITEMS = 1650;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [47:0] s_axis_tdata  = '0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [15:0] m_axis_tdata;

  int mismatches;
  int outstanding;
  int cycles = 0;
  bit steady = 1'b0;
  bit seeded0 [NUM_LANES];
  bit seeded1 [NUM_LANES];

  fixed_point_lane_alu_stochastic_round dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lane_alu_monitor alu_monitor (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 15);
    end
  end

  task automatic issue(input logic [4:0] fn, input logic [4:0] ln, input logic [15:0] a,
                       input logic [15:0] b, input logic [3:0] fs, input logic sat);
    s_axis_tdata  <= {1'b0, sat, fs, b, a, ln, fn};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (fn == FN_SEED0) seeded0[ln] = 1'b1;
    if (fn == FN_SEED1) seeded1[ln] = 1'b1;
    if (!steady && $urandom_range(0, 99) < 7) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [4:0] fn;
    logic [4:0] ln;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(FN_SEED0,   5'd0,  16'h0001, 16'h0000, 4'd0,  1'b0);
    issue(FN_SEED1,   5'd0,  16'h0000, 16'h0000, 4'd0,  1'b0);
    issue(FN_SEED0,   5'd31, 16'hffff, 16'h0000, 4'd0,  1'b0);
    issue(FN_SEED1,   5'd31, 16'h8000, 16'h0000, 4'd0,  1'b0);
    issue(FN_ADD,     5'd3,  16'h7fff, 16'h7fff, 4'd0,  1'b1);
    issue(FN_ADD,     5'd3,  16'h7fff, 16'h7fff, 4'd0,  1'b0);
    issue(FN_SUB,     5'd3,  16'h8000, 16'h7fff, 4'd0,  1'b1);
    issue(FN_SLL,     5'd3,  16'h0001, 16'hffff, 4'd0,  1'b0);
    issue(FN_SRA,     5'd3,  16'h8000, 16'h000f, 4'd0,  1'b1);
    issue(FN_MUL,     5'd3,  16'h8000, 16'h8000, 4'd15, 1'b1);
    issue(FN_MUL_RN,  5'd3,  16'h7fff, 16'h7fff, 4'd0,  1'b0);
    issue(FN_MUL_RN,  5'd3,  16'hffff, 16'h0001, 4'd15, 1'b1);
    issue(FN_MUL_RS,  5'd0,  16'h1234, 16'h8000, 4'd0,  1'b0);
    issue(FN_MUL_RS,  5'd31, 16'h7fff, 16'h7fff, 4'd15, 1'b1);
    issue(FN_SLLI,    5'd3,  16'h7fff, 16'h0000, 4'd15, 1'b1);
    issue(FN_SRAI,    5'd3,  16'h8000, 16'h0000, 4'd15, 1'b0);
    issue(FN_SRAI_RN, 5'd3,  16'hffff, 16'h0000, 4'd0,  1'b0);
    issue(FN_SRAI_RS, 5'd31, 16'h7fff, 16'h0000, 4'd8,  1'b0);
    issue(FN_RNG,     5'd0,  16'h0000, 16'h0000, 4'd0,  1'b0);
    issue(FN_ANDADD,  5'd3,  16'hffff, 16'h7fff, 4'd15, 1'b1);
    issue(FN_ANDADD,  5'd3,  16'hffff, 16'h8000, 4'd0,  1'b0);
    issue(FN_EQ,      5'd3,  16'h8000, 16'h8000, 4'd0,  1'b0);
    issue(FN_NE,      5'd3,  16'h8000, 16'h8000, 4'd0,  1'b0);
    issue(FN_LT,      5'd3,  16'h8000, 16'h7fff, 4'd0,  1'b0);
    issue(FN_GE,      5'd3,  16'h7fff, 16'h8000, 4'd0,  1'b0);
    issue(5'd31,      5'd3,  16'hffff, 16'hffff, 4'd15, 1'b1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 500) drain();
      if (i == 800) steady = 1'b1;
      if (i == 1100) steady = 1'b0;
      fn = ($urandom_range(0, 99) < 4) ? 5'($urandom_range(20, 31))
                                       : 5'($urandom_range(0, 19));
      ln = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
      if ((fn == FN_MUL_RS || fn == FN_SRAI_RS || fn == FN_RNG) &&
          !(seeded0[ln] && seeded1[ln])) begin
        fn = seeded0[ln] ? FN_SEED1 : FN_SEED0;
      end else if ($urandom_range(0, 99) < 3) begin
        fn = $urandom_range(0, 1) ? FN_SEED1 : FN_SEED0;
      end
      issue(fn, ln, pick_word(), pick_word(), 4'($urandom), 1'($urandom));
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
